// File: rtl/core/rrf_pkg.sv
// Shared types and constants of the request framer.
`timescale 1ns / 1ps

package rrf_pkg;

    // Width of the count and length digit accumulator.
    localparam int unsigned LEN_BITS = 32;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef enum logic [8:0] {
        PH_COUNT_START  = 9'b000000001,
        PH_COUNT_DIGITS = 9'b000000010,
        PH_COUNT_LF     = 9'b000000100,
        PH_LEN_START    = 9'b000001000,
        PH_LEN_DIGITS   = 9'b000010000,
        PH_LEN_LF       = 9'b000100000,
        PH_CONTENT      = 9'b001000000,
        PH_CONTENT_LF   = 9'b010000000,
        PH_ERROR        = 9'b100000000
    } phase_t;

    typedef struct packed {
        status_t    status;
        logic       content_valid;
        logic [7:0] content_byte;
        logic [7:0] param_index;
        logic       param_end;
    } res_t;

endpackage

// File: rtl/core/resp_request_framer.sv
// Request framer: parses '*'-counted arrays of '$'-length bulk strings, one byte per word.
`timescale 1ns / 1ps

// Takes one request byte per word and returns exactly one result word per byte:
// status (need more, request complete, format error), the content byte with its
// parameter index, and a mark on the CR that closes a parameter. One byte is
// parsed per clock; the parse state, digit accumulator and content counter
// update in the cycle the byte is taken, and the result lands in a two-entry
// output buffer, so a byte can be taken every cycle while results drain, and
// the input stalls only when both buffer entries hold untaken results. Each
// result is registered in the buffer before it reaches the output. Format
// errors stick until reset. The parameter count limit may be written only
// while the framer is idle.
module resp_request_framer
    import rrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] in_byte,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] status,
    output logic       content_valid,
    output logic [7:0] content_byte,
    output logic [7:0] param_index,
    output logic       param_end
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    logic [7:0]          max_count_reg;
    phase_t              phase_reg, phase_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic                seen_reg, seen_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          done_reg, done_next;
    logic [LEN_BITS-1:0] remain_reg, remain_next;
    logic                over_reg, over_next;

    res_t head_reg, head_next;
    res_t skid_reg, skid_next;
    logic head_valid_reg, head_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic                accept;
    logic                pop;
    logic                is_digit;
    logic [3:0]          digit;
    logic [LEN_BITS+3:0] acc_times_ten;
    logic                acc_ovf;
    logic [LEN_BITS-1:0] acc_added;
    res_t                res;

    assign cfg_ready = 1'b1;
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign pop       = head_valid_reg && !rsp_stall;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit    = 4'(in_byte - CH_ZERO);

    // acc * 10 + digit, with the bits above LEN_BITS flagging overflow.
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                           + {{LEN_BITS{1'b0}}, digit};
    assign acc_ovf       = |acc_times_ten[LEN_BITS+3:LEN_BITS];
    assign acc_added     = acc_ovf ? LEN_MAX : acc_times_ten[LEN_BITS-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        remain_next = remain_reg;
        over_next   = over_reg;
        res         = '{status: ST_MORE, content_valid: 1'b0, content_byte: 8'd0,
                        param_index: 8'd0, param_end: 1'b0};

        unique case (phase_reg)
            PH_COUNT_START:
            begin
                acc_next  = '0;
                seen_next = 1'b0;
                phase_next = (in_byte == CH_STAR) ? PH_COUNT_DIGITS : PH_ERROR;
            end
            PH_COUNT_DIGITS:
            begin
                if (in_byte == CH_CR)
                begin
                    if (!seen_reg || acc_reg == '0
                        || acc_reg > {{(LEN_BITS-8){1'b0}}, max_count_reg})
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        count_next = acc_reg[7:0];
                        done_next  = 8'd0;
                        phase_next = PH_COUNT_LF;
                    end
                    acc_next  = '0;
                    seen_next = 1'b0;
                end
                else if (is_digit)
                begin
                    // The count saturates rather than erring on overflow.
                    acc_next  = acc_added;
                    seen_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_COUNT_LF:
            begin
                phase_next = (in_byte == CH_LF) ? PH_LEN_START : PH_ERROR;
            end
            PH_LEN_START:
            begin
                acc_next  = '0;
                seen_next = 1'b0;
                phase_next = (in_byte == CH_DOLLAR) ? PH_LEN_DIGITS : PH_ERROR;
            end
            PH_LEN_DIGITS:
            begin
                if (in_byte == CH_CR)
                begin
                    if (!seen_reg)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        remain_next = acc_reg;
                        phase_next  = PH_LEN_LF;
                    end
                    acc_next  = '0;
                    seen_next = 1'b0;
                end
                else if (is_digit)
                begin
                    acc_next  = acc_added;
                    seen_next = 1'b1;
                    if (acc_ovf)
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                else
                begin
                    phase_next = PH_ERROR;
                end
            end
            PH_LEN_LF:
            begin
                over_next  = 1'b0;
                phase_next = (in_byte == CH_LF) ? PH_CONTENT : PH_ERROR;
            end
            PH_CONTENT:
            begin
                if (in_byte != CH_CR)
                begin
                    res.content_valid = 1'b1;
                    res.content_byte  = in_byte;
                    res.param_index   = done_reg;
                    // Count down the declared length; one byte past it marks overrun.
                    if (remain_reg == '0)
                    begin
                        over_next = 1'b1;
                    end
                    else
                    begin
                        remain_next = remain_reg - LEN_BITS'(1);
                    end
                end
                else if (over_reg)
                begin
                    phase_next = PH_ERROR;
                end
                else
                begin
                    res.param_end   = 1'b1;
                    res.param_index = done_reg;
                    done_next       = done_reg + 8'd1;
                    phase_next      = PH_CONTENT_LF;
                end
            end
            PH_CONTENT_LF:
            begin
                if (in_byte != CH_LF)
                begin
                    phase_next = PH_ERROR;
                end
                else if (done_reg == count_reg)
                begin
                    res.status = ST_DONE;
                    done_next  = 8'd0;
                    count_next = 8'd0;
                    phase_next = PH_COUNT_START;
                end
                else
                begin
                    phase_next = PH_LEN_START;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        if (phase_next == PH_ERROR)
        begin
            res = '{status: ST_ERR, content_valid: 1'b0, content_byte: 8'd0,
                    param_index: 8'd0, param_end: 1'b0};
        end
    end

    // Two-entry output buffer: head drives the ports, skid catches a result
    // taken while the head is stalled.
    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                head_next = res;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (head_valid_reg)
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                head_next       = res;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg  <= 8'd255;
            phase_reg      <= PH_COUNT_START;
            acc_reg        <= '0;
            seen_reg       <= 1'b0;
            count_reg      <= 8'd0;
            done_reg       <= 8'd0;
            remain_reg     <= '0;
            over_reg       <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_count_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                count_reg  <= count_next;
                done_reg   <= done_next;
                remain_reg <= remain_next;
                over_reg   <= over_next;
            end
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid     = head_valid_reg;
    assign status        = head_reg.status;
    assign content_valid = head_reg.content_valid;
    assign content_byte  = head_reg.content_byte;
    assign param_index   = head_reg.param_index;
    assign param_end     = head_reg.param_end;

endmodule

// File: rtl/core/rrf_checker.sv
// Port-level assertions for the request framer, bound to the top level.
`timescale 1ns / 1ps

module rrf_checker
    import rrf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic [1:0] status,
    input logic       content_valid,
    input logic [7:0] content_byte,
    input logic [7:0] param_index,
    input logic       param_end
);

    logic err_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else if (rsp_valid && !rsp_stall && status == ST_ERR)
        begin
            err_seen_reg <= 1'b1;
        end
    end

    // Once an error word has been delivered, every later word is an error.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && err_seen_reg |-> status == ST_ERR)
        else $error("error status did not persist");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_ERR |->
            !content_valid && content_byte == 8'd0 && param_index == 8'd0 && !param_end)
        else $error("error word carries payload");

    a_content_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (content_valid || param_end) |->
            status == ST_MORE && !(content_valid && param_end))
        else $error("content and parameter end overlap or carry a status");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(content_byte) && $stable(param_index))
        else $error("stalled result word changed");

endmodule

bind resp_request_framer rrf_checker u_rrf_checker (.*);

// File: tb/sv/rrf_frame_checker.sv
// Checker for the request framer: watches all channels, predicts each result word and compares.
`timescale 1ns / 1ps

module rrf_frame_checker
    import rrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic [7:0] in_byte,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  logic [1:0] status,
    input  logic       content_valid,
    input  logic [7:0] content_byte,
    input  logic [7:0] param_index,
    input  logic       param_end,
    output int         pending,
    output int         fails
);

    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);

    // Shadow copy of the framer state.
    phase_t      phase;
    logic [63:0] digit_acc;
    logic        digit_seen;
    logic [7:0]  declared_count;
    logic [7:0]  params_done;
    logic [63:0] declared_len;
    logic [63:0] body_len;
    logic [7:0]  count_limit;

    res_t expected_words[$];
    int   words_checked;

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        $display("mismatch on result word %0d: %s is %0h, expected %0h",
                 words_checked, what, got_v, want_v);
        fails = fails + 1;
    endtask

    // Adds one decimal digit; on overflow the accumulator saturates and 0 is returned.
    function automatic logic add_digit(input logic [3:0] d);
        digit_seen = 1'b1;
        if (digit_acc > (LEN_MAX - 64'(d)) / 10) begin
            digit_acc = LEN_MAX;
            return 1'b0;
        end
        digit_acc = digit_acc * 10 + 64'(d);
        return 1'b1;
    endfunction

    function automatic res_t frame_byte(input logic [7:0] b);
        res_t   r;
        phase_t nxt;
        logic   is_digit;
        r = '0;
        r.status = ST_MORE;
        nxt = phase;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (phase)
            PH_COUNT_START:
                if (b == CH_STAR) begin
                    digit_acc = '0;
                    digit_seen = 1'b0;
                    nxt = PH_COUNT_DIGITS;
                end else
                    nxt = PH_ERROR;
            PH_COUNT_DIGITS:
                if (b == CH_CR) begin
                    if (!digit_seen || digit_acc == 0 || digit_acc > 64'(count_limit))
                        nxt = PH_ERROR;
                    else begin
                        declared_count = digit_acc[7:0];
                        params_done = '0;
                        nxt = PH_COUNT_LF;
                    end
                    digit_acc = '0;
                    digit_seen = 1'b0;
                end else if (is_digit)
                    // A count that overflows saturates and fails at its CR.
                    void'(add_digit(b[3:0]));
                else
                    nxt = PH_ERROR;
            PH_COUNT_LF:
                nxt = (b == CH_LF) ? PH_LEN_START : PH_ERROR;
            PH_LEN_START:
                if (b == CH_DOLLAR) begin
                    digit_acc = '0;
                    digit_seen = 1'b0;
                    nxt = PH_LEN_DIGITS;
                end else
                    nxt = PH_ERROR;
            PH_LEN_DIGITS:
                if (b == CH_CR) begin
                    if (!digit_seen)
                        nxt = PH_ERROR;
                    else begin
                        declared_len = digit_acc;
                        nxt = PH_LEN_LF;
                    end
                    digit_acc = '0;
                    digit_seen = 1'b0;
                end else if (is_digit) begin
                    if (!add_digit(b[3:0]))
                        nxt = PH_ERROR;
                end else
                    nxt = PH_ERROR;
            PH_LEN_LF:
                if (b == CH_LF) begin
                    body_len = '0;
                    nxt = PH_CONTENT;
                end else
                    nxt = PH_ERROR;
            PH_CONTENT:
                if (b != CH_CR) begin
                    r.content_valid = 1'b1;
                    r.content_byte = b;
                    r.param_index = params_done;
                    if (body_len <= declared_len && body_len != '1)
                        body_len = body_len + 1;
                end else if (body_len > declared_len)
                    nxt = PH_ERROR;
                else begin
                    r.param_end = 1'b1;
                    r.param_index = params_done;
                    params_done = params_done + 1;
                    nxt = PH_CONTENT_LF;
                end
            PH_CONTENT_LF:
                if (b != CH_LF)
                    nxt = PH_ERROR;
                else if (params_done == declared_count) begin
                    r.status = ST_DONE;
                    params_done = '0;
                    declared_count = '0;
                    nxt = PH_COUNT_START;
                end else
                    nxt = PH_LEN_START;
            default:
                nxt = PH_ERROR;
        endcase
        phase = nxt;
        if (nxt == PH_ERROR) begin
            r = '0;
            r.status = ST_ERR;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            phase = PH_COUNT_START;
            digit_acc = '0;
            digit_seen = 1'b0;
            declared_count = '0;
            params_done = '0;
            declared_len = '0;
            body_len = '0;
            count_limit = 8'd255;
            expected_words.delete();
            words_checked = 0;
            fails = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_limit = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                got.status = status_t'(status);
                got.content_valid = content_valid;
                got.content_byte = content_byte;
                got.param_index = param_index;
                got.param_end = param_end;
                if (expected_words.size() == 0)
                begin
                    $display("result word %0d arrived with no byte outstanding",
                             words_checked);
                    fails = fails + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 8'(got.status), 8'(want.status));
                    if (got.content_valid != want.content_valid)
                        report_mismatch("content_valid", 8'(got.content_valid),
                                        8'(want.content_valid));
                    if (got.content_byte != want.content_byte)
                        report_mismatch("content_byte", got.content_byte, want.content_byte);
                    if (got.param_index != want.param_index)
                        report_mismatch("param_index", got.param_index, want.param_index);
                    if (got.param_end != want.param_end)
                        report_mismatch("param_end", 8'(got.param_end), 8'(want.param_end));
                end
                words_checked = words_checked + 1;
            end
            if (req_valid && !req_stall)
                expected_words.push_back(frame_byte(in_byte));
            pending <= expected_words.size();
        end
    end

endmodule

// File: tb/sv/resp_request_framer_tb.sv
// Top of the request framer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module resp_request_framer_tb;
    import rrf_pkg::*;

    localparam longint unsigned LEN_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);
    localparam int HOLD_CYCLES = 48;

    typedef enum int {
        FL_COUNT_MARKER,
        FL_COUNT_CHAR,
        FL_COUNT_EMPTY,
        FL_COUNT_ZERO,
        FL_COUNT_OVER,
        FL_COUNT_HUGE,
        FL_COUNT_LF,
        FL_LEN_MARKER,
        FL_LEN_CHAR,
        FL_LEN_EMPTY,
        FL_LEN_OVER,
        FL_LEN_LF,
        FL_BODY_LONG,
        FL_BODY_LF
    } flaw_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       req_valid;
    logic       req_stall;
    logic [7:0] in_byte;
    logic       rsp_valid;
    logic       rsp_stall;
    logic [1:0] status;
    logic       content_valid;
    logic [7:0] content_byte;
    logic [7:0] param_index;
    logic       param_end;
    int         pending;
    int         fails;

    logic [7:0] tx_bytes[$];
    int         bytes_sent;
    int         req_idle_pct;
    int         stall_pct;
    int         hold_asked;
    int         hold_served;
    logic [7:0] tb_limit;

    resp_request_framer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .in_byte       (in_byte),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .content_valid (content_valid),
        .content_byte  (content_byte),
        .param_index   (param_index),
        .param_end     (param_end)
    );

    rrf_frame_checker frame_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .in_byte       (in_byte),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .content_valid (content_valid),
        .content_byte  (content_byte),
        .param_index   (param_index),
        .param_end     (param_end),
        .pending       (pending),
        .fails         (fails)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is asked for.
    initial
    begin
        rsp_stall = 1'b0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_served + 1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void put_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
    endfunction

    function automatic void put_number(input longint unsigned v, input int zeros);
        logic [7:0] digits[$];
        repeat (zeros) tx_bytes.push_back(CH_ZERO);
        do
        begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        tx_bytes = {tx_bytes, digits};
    endfunction

    // Random byte outside lo..hi that is not a CR either.
    function automatic logic [7:0] odd_byte(input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while ((b >= lo && b <= hi) || b == CH_CR);
        return b;
    endfunction

    function automatic void put_count(input longint unsigned n, input int zeros);
        put_byte(CH_STAR);
        put_number(n, zeros);
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    // One bulk string: declared length, then body_n content bytes (never CR).
    function automatic void put_param(input longint unsigned declared, input int body_n,
                                      input int zeros);
        put_byte(CH_DOLLAR);
        put_number(declared, zeros);
        put_byte(CH_CR);
        put_byte(CH_LF);
        repeat (body_n) put_byte(odd_byte(CH_CR, CH_CR));
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic int some_zeros();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_frame();
        foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        tb_limit = v;
    endtask

    task automatic random_requests(input int budget);
        int first;
        int n;
        int body_n;
        longint unsigned declared;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            n = $urandom_range(1, (tb_limit < 5) ? tb_limit : 5);
            if ($urandom_range(7) == 0 && tb_limit <= 8)
                n = tb_limit;
            put_count(n, some_zeros());
            repeat (n)
            begin
                case ($urandom_range(15))
                    0: begin
                        // Huge declared length with a short body.
                        declared = longint'($urandom) & LEN_LIMIT;
                        body_n = $urandom_range(0, 4);
                    end
                    1: begin
                        declared = 0;
                        body_n = 0;
                    end
                    default: begin
                        declared = $urandom_range(0, 8);
                        body_n = ($urandom_range(3) == 0) ? $urandom_range(0, int'(declared))
                                                          : int'(declared);
                    end
                endcase
                put_param(declared, body_n, some_zeros());
            end
            send_frame();
        end
    endtask

    // Ends the stream with one malformed request; the framer stays in error from there.
    task automatic broken_request(input flaw_t flaw);
        case (flaw)
            FL_COUNT_MARKER: put_byte(odd_byte(CH_STAR, CH_STAR));
            FL_COUNT_CHAR: begin
                put_byte(CH_STAR);
                put_byte(CH_ZERO + 8'd1);
                put_byte(odd_byte(CH_ZERO, CH_NINE));
            end
            FL_COUNT_EMPTY: begin
                put_byte(CH_STAR);
                put_byte(CH_CR);
            end
            FL_COUNT_ZERO: begin
                put_byte(CH_STAR);
                put_number(0, $urandom_range(0, 2));
                put_byte(CH_CR);
            end
            FL_COUNT_OVER: begin
                put_byte(CH_STAR);
                put_number(longint'(tb_limit) + 1, 0);
                put_byte(CH_CR);
            end
            FL_COUNT_HUGE: begin
                put_byte(CH_STAR);
                put_number(64'd99_999_999_999, 0);
                put_byte(CH_CR);
            end
            FL_COUNT_LF: begin
                put_byte(CH_STAR);
                put_number(1, 0);
                put_byte(CH_CR);
                put_byte(odd_byte(CH_LF, CH_LF));
            end
            FL_LEN_MARKER: begin
                put_count(1, 0);
                put_byte(odd_byte(CH_DOLLAR, CH_DOLLAR));
            end
            FL_LEN_CHAR: begin
                put_count(1, 0);
                put_byte(CH_DOLLAR);
                put_number(3, 0);
                put_byte(odd_byte(CH_ZERO, CH_NINE));
            end
            FL_LEN_EMPTY: begin
                put_count(1, 0);
                put_byte(CH_DOLLAR);
                put_byte(CH_CR);
            end
            FL_LEN_OVER: begin
                put_count(1, 0);
                put_byte(CH_DOLLAR);
                put_number(LEN_LIMIT + 1, 0);
            end
            FL_LEN_LF: begin
                put_count(1, 0);
                put_byte(CH_DOLLAR);
                put_number(1, 0);
                put_byte(CH_CR);
                put_byte(odd_byte(CH_LF, CH_LF));
            end
            FL_BODY_LONG: begin
                put_count(1, 0);
                put_byte(CH_DOLLAR);
                put_number(2, 0);
                put_byte(CH_CR);
                put_byte(CH_LF);
                repeat (3) put_byte(odd_byte(CH_CR, CH_CR));
                put_byte(CH_CR);
            end
            default: begin
                put_count(1, 0);
                put_param(0, 0, 0);
                void'(tx_bytes.pop_back());
                put_byte(odd_byte(CH_LF, CH_LF));
            end
        endcase
        repeat (40) put_byte(8'($urandom_range(255)));
        send_frame();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        in_byte = '0;
        bytes_sent = 0;
        req_idle_pct = 0;
        stall_pct = 0;
        hold_asked = 0;
        tb_limit = 8'd255;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leading zero in the count, bytes 00, FF and LF inside content,
        // and a body far shorter than the largest declared length.
        put_count(2, 1);
        put_param(1, 0, 0);
        void'(tx_bytes.pop_back());
        void'(tx_bytes.pop_back());
        put_byte(8'hFF);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_param(LEN_LIMIT, 0, 0);
        repeat (2) void'(tx_bytes.pop_back());
        put_byte(8'h00);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put_byte(CH_LF);
        send_frame();
        wait_drained();

        // Smallest limit: count equal to it, with an empty parameter.
        write_limit(8'd1);
        put_count(1, 0);
        put_param(0, 0, 0);
        send_frame();
        random_requests(300);
        wait_drained();

        write_limit(8'd255);
        req_idle_pct = 76;
        random_requests(300);
        wait_drained();

        write_limit(8'($urandom_range(2, 8)));
        req_idle_pct = 0;
        stall_pct <= 76;
        random_requests(300);
        wait_drained();

        // The receiver holds off while bytes keep coming, so the framer backs up.
        write_limit(8'($urandom_range(2, 254)));
        stall_pct <= 0;
        hold_asked <= hold_asked + 1;
        random_requests(60);
        req_idle_pct = 12;
        stall_pct <= 12;
        random_requests(300);
        wait_drained();

        req_idle_pct = 0;
        stall_pct <= 0;
        broken_request(flaw_t'($urandom_range(FL_BODY_LF)));
        wait_drained();
        repeat (4) @(posedge clk);

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
